### hw/rtl/sspc_pkg.sv
// ----------------------------------------------------------------------------
// sspc_pkg - shared types and constants of the servo status packet checker
// Status codes, packet constants and the check result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sspc_pkg;

    localparam int unsigned BufferDepthDefault = 8;
    localparam logic [7:0]  DeviceIdReset      = 8'd1;

    localparam logic [7:0]  HdrByte  = 8'hFF;
    localparam int unsigned MinBytes = 6;
    localparam logic [7:0]  LenMin   = 8'd2;
    localparam logic [7:0]  LenMax   = 8'd4;
    // bytes before the checksum that are not counted in the length field
    localparam logic [3:0]  LenOverhead = 4'd4;
    // the checker only ever looks at the first eight stored bytes
    localparam int unsigned CheckBytes = 8;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_RESPONSE  = 3'd1,
        ST_INCOMPLETE   = 3'd2,
        ST_BAD_HEADER   = 3'd3,
        ST_ID_MISMATCH  = 3'd4,
        ST_BAD_LENGTH   = 3'd5,
        ST_BAD_CHECKSUM = 3'd6
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] value;
        logic        load_err;
        logic [7:0]  err_byte;
    } t_check_res;

endpackage

`default_nettype wire

### hw/rtl/servo_status_packet_checker_core.sv
// ----------------------------------------------------------------------------
// servo_status_packet_checker_core - servo status reply checker
// Collects reply bytes and checks the packet on each end-of-reception item.
// ----------------------------------------------------------------------------
// Each input item is either a received byte (tuser 0) or an end-of-reception
// mark (tuser 1). Bytes are stored up to BUFFER_DEPTH, later ones dropped. An
// end mark yields one result item with status, value and the latched servo
// error byte, and clears the byte count. An item is taken into the input
// register; the check runs combinationally on the stored bytes and the result
// register loads when the end mark leaves the input register. Data bytes move
// on every cycle; an end mark waits only while an earlier result is still held
// and not taken, so throughput is one item per cycle while no end mark waits.
// The device id register is written through i_cfg_wr_en / i_cfg_wr_data; the
// user must do so only while the block is idle, which the block does not enforce.
`default_nettype none

module servo_status_packet_checker_core #(
    parameter int unsigned BUFFER_DEPTH = sspc_pkg::BufferDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [2:0] status, [18:3] value,
                                             // [26:19] servo_error, rest zero
);

    localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned IdxW = $clog2(BUFFER_DEPTH);

    logic [7:0]            r_device_id;
    logic                  r_in_valid;
    logic                  r_in_func;
    logic [7:0]            r_in_byte;
    logic [7:0]            r_store [BUFFER_DEPTH];
    logic [CntW-1:0]       r_count;
    logic [7:0]            r_servo_err;
    logic                  r_out_valid;
    sspc_pkg::t_status     r_out_status;
    logic [15:0]           r_out_value;
    logic [7:0]            r_out_err;

    logic                  advance;
    logic [7:0]            n_servo_err;
    logic [sspc_pkg::CheckBytes-1:0][7:0] chk_bytes;
    sspc_pkg::t_check_res  chk_res;

    // data bytes never touch the result register
    assign advance = r_in_valid && (!r_in_func || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        for (int i = 0; i < sspc_pkg::CheckBytes; i++) begin
            chk_bytes[i] = r_store[i];
        end
    end

    sspc_check #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_check (
        .i_bytes     (chk_bytes),
        .i_count     (r_count),
        .i_device_id (r_device_id),
        .o_res       (chk_res)
    );

    assign n_servo_err = chk_res.load_err ? chk_res.err_byte : r_servo_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= sspc_pkg::DeviceIdReset;
        end else if (i_cfg_wr_en) begin
            r_device_id <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    // byte store and count
    always_ff @(posedge i_clk) begin
        if (advance && !r_in_func && r_count < CntW'(BUFFER_DEPTH)) begin
            r_store[r_count[IdxW-1:0]] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_servo_err <= '0;
        end else if (advance) begin
            if (r_in_func) begin
                r_count     <= '0;
                r_servo_err <= n_servo_err;
            end else if (r_count < CntW'(BUFFER_DEPTH)) begin
                r_count <= r_count + CntW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_func) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_func) begin
            r_out_status <= chk_res.status;
            r_out_value  <= chk_res.value;
            r_out_err    <= n_servo_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_err, r_out_value, r_out_status};

endmodule

`default_nettype wire

### hw/rtl/sspc_check.sv
// ----------------------------------------------------------------------------
// sspc_check - packet check logic
// Checks the stored reply bytes and count and gives status, value and error.
// ----------------------------------------------------------------------------
`default_nettype none

module sspc_check #(
    parameter int unsigned BUFFER_DEPTH = sspc_pkg::BufferDepthDefault,
    localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1)
) (
    input  wire logic [sspc_pkg::CheckBytes-1:0][7:0] i_bytes,
    input  wire logic [CntW-1:0]                      i_count,
    input  wire logic [7:0]                           i_device_id,
    output sspc_pkg::t_check_res                      o_res
);

    logic [7:0]  len;
    logic [2:0]  len_s;
    logic [CntW-1:0] need;
    logic [7:0]  sum;
    logic [7:0]  chk;
    logic        len_ok;

    assign len   = i_bytes[3];
    assign len_s = len[2:0];
    assign need  = CntW'(len_s) + CntW'(sspc_pkg::LenOverhead);
    assign len_ok = (len >= sspc_pkg::LenMin) && (len <= sspc_pkg::LenMax);

    // sum of id through last parameter (inverted at the compare) and the checksum byte
    always_comb begin
        sum = i_bytes[2] + i_bytes[3] + i_bytes[4];
        if (len_s >= 3'd3) begin
            sum = sum + i_bytes[5];
        end
        if (len_s == 3'd4) begin
            sum = sum + i_bytes[6];
        end
        case (len_s)
            3'd2:    chk = i_bytes[5];
            3'd3:    chk = i_bytes[6];
            default: chk = i_bytes[7];
        endcase
    end

    always_comb begin
        o_res.value    = '0;
        o_res.load_err = 1'b0;
        o_res.err_byte = i_bytes[4];
        if (i_count == '0) begin
            o_res.status = sspc_pkg::ST_NO_RESPONSE;
        end else if (i_count < CntW'(sspc_pkg::MinBytes)) begin
            o_res.status = sspc_pkg::ST_INCOMPLETE;
        end else if (i_bytes[0] != sspc_pkg::HdrByte || i_bytes[1] != sspc_pkg::HdrByte) begin
            o_res.status = sspc_pkg::ST_BAD_HEADER;
        end else if (i_bytes[2] != i_device_id) begin
            o_res.status = sspc_pkg::ST_ID_MISMATCH;
        end else if (!len_ok) begin
            o_res.status = sspc_pkg::ST_BAD_LENGTH;
        end else if (i_count < need) begin
            o_res.status = sspc_pkg::ST_INCOMPLETE;
        end else if (~sum != chk) begin
            o_res.status = sspc_pkg::ST_BAD_CHECKSUM;
        end else begin
            o_res.status   = sspc_pkg::ST_OK;
            o_res.load_err = 1'b1;
            case (len_s)
                3'd3:    o_res.value = {8'd0, i_bytes[5]};
                3'd4:    o_res.value = {i_bytes[6], i_bytes[5]};
                default: o_res.value = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

### test/servo_status_packet_checker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_status_packet_checker_core_tb - self-checking bench of the reply checker
// Feeds reply bytes and end marks: a directed table first, then random packets
// that are mostly well-formed. The block's verdicts are checked field by field
// against a local model, across several device ids and handshake idling modes.
// ----------------------------------------------------------------------------
module servo_status_packet_checker_core_tb;

    localparam int BufDepth    = sspc_pkg::BufferDepthDefault;
    localparam int DrainCycles = 4;
    localparam int StallLimit  = 4000;
    localparam int LongHold    = 400;

    typedef struct packed {
        sspc_pkg::t_status status;
        logic [15:0]       value;
        logic [7:0]        servo_error;
    } t_verdict;

    // one row of the directed table; a typed verdict is used only on end marks
    typedef struct packed {
        logic              is_end;
        logic [7:0]        data;
        logic              typed;
        sspc_pkg::t_status status;
        logic [15:0]       value;
        logic [7:0]        servo_error;
    } t_row;

    localparam t_row DirRows [25] = '{
        // end mark straight after reset
        '{1'b1, 8'h00, 1'b1, sspc_pkg::ST_NO_RESPONSE,  16'h0000, 8'h00},
        // four-byte length, two parameters, then one byte past a full store
        '{1'b0, 8'hFF, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'hFF, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h01, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h04, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h80, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h34, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h12, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h34, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h00, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b1, 8'h00, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        // length asks for more bytes than arrived
        '{1'b0, 8'hFF, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'hFF, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h01, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h04, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h00, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h00, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b1, 8'h00, 1'b1, sspc_pkg::ST_INCOMPLETE,   16'h0000, 8'h80},
        // zero checksum byte where FC is due
        '{1'b0, 8'hFF, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'hFF, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h01, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h02, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h00, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b0, 8'h00, 1'b0, sspc_pkg::ST_OK,           16'h0000, 8'h00},
        '{1'b1, 8'h00, 1'b1, sspc_pkg::ST_BAD_CHECKSUM, 16'h0000, 8'h80}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [2:0] status, [18:3] value, [26:19] servo_error

    // local copy of the block state
    logic [7:0] pkt_bytes [BufDepth];
    int         pkt_count;
    logic [7:0] held_err;
    logic [7:0] dev_id;

    t_verdict pending_verdicts [$];

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_trigger;
    bit  hold_seen;
    int  hold_left;
    int  stall_cycles;
    int  mismatches;
    int  items_fed;
    int  checks_done;
    int  cfg_writes;
    int  status_hits [7];

    servo_status_packet_checker_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // takes one item into the local state; returns 1 when an end mark gives a verdict
    function automatic bit judge_item(input bit is_end, input logic [7:0] b,
                                      output t_verdict v);
        int         len;
        int         i;
        logic [7:0] acc;
        v = '0;
        if (!is_end) begin
            if (pkt_count < BufDepth) begin
                pkt_bytes[pkt_count] = b;
                pkt_count++;
            end
            return 1'b0;
        end
        v.status = sspc_pkg::ST_OK;
        if (pkt_count == 0) begin
            v.status = sspc_pkg::ST_NO_RESPONSE;
        end else if (pkt_count < sspc_pkg::MinBytes) begin
            v.status = sspc_pkg::ST_INCOMPLETE;
        end else if (pkt_bytes[0] != sspc_pkg::HdrByte ||
                     pkt_bytes[1] != sspc_pkg::HdrByte) begin
            v.status = sspc_pkg::ST_BAD_HEADER;
        end else if (pkt_bytes[2] != dev_id) begin
            v.status = sspc_pkg::ST_ID_MISMATCH;
        end else if (pkt_bytes[3] < sspc_pkg::LenMin || pkt_bytes[3] > sspc_pkg::LenMax) begin
            v.status = sspc_pkg::ST_BAD_LENGTH;
        end else if (pkt_count < int'(pkt_bytes[3]) + 4) begin
            v.status = sspc_pkg::ST_INCOMPLETE;
        end else begin
            len = pkt_bytes[3];
            acc = 8'h00;
            for (i = 2; i <= 2 + len; i++) acc += pkt_bytes[i];
            if (~acc != pkt_bytes[3 + len]) begin
                v.status = sspc_pkg::ST_BAD_CHECKSUM;
            end else begin
                held_err = pkt_bytes[4];
                if (len == 3) v.value = {8'h00, pkt_bytes[5]};
                else if (len == 4) v.value = {pkt_bytes[6], pkt_bytes[5]};
            end
        end
        v.servo_error = held_err;
        pkt_count = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // offers one item, idling first at the current rate, and waits until taken
    task automatic send_item(input bit is_end, input logic [7:0] b,
                             input bit use_typed, input t_verdict typed_v);
        t_verdict v;
        bit       ignored;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= is_end;
        do @(posedge i_clk); while (!s_axis_tready);
        ignored = !is_end && pkt_count >= BufDepth;
        if (!ignored) items_fed++;
        if (judge_item(is_end, b, v))
            pending_verdicts.push_back(use_typed ? typed_v : v);
    endtask

    task automatic write_device_id(input logic [7:0] id);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= id;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dev_id = id;
        cfg_writes++;
    endtask

    // builds one reply, mostly well-formed, sometimes broken, and ends it
    task automatic send_random_packet();
        logic [7:0] pkt [$];
        int         kind;
        int         len;
        int         n;
        int         i;
        logic [7:0] acc;
        logic [7:0] x;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(sspc_pkg::LenMin, sspc_pkg::LenMax);
        pkt.push_back(sspc_pkg::HdrByte);
        pkt.push_back(sspc_pkg::HdrByte);
        pkt.push_back(dev_id);
        pkt.push_back(8'(len));
        pkt.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < len - 2; i++) pkt.push_back(8'($urandom_range(0, 255)));
        acc = 8'h00;
        for (i = 2; i < pkt.size(); i++) acc += pkt[i];
        pkt.push_back(~acc);
        if (kind < 55) begin
            // well-formed
        end else if (kind < 62) begin
            x = 8'($urandom_range(0, 254));
            pkt[$urandom_range(0, 1)] = x;
        end else if (kind < 69) begin
            pkt[2] = dev_id ^ 8'($urandom_range(1, 255));
        end else if (kind < 75) begin
            // length outside 2..4
            x = 8'($urandom_range(0, 252));
            if (x >= sspc_pkg::LenMin) x = x + 8'd3;
            pkt[3] = x;
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 82) begin
            pkt[pkt.size() - 1] = pkt[pkt.size() - 1] ^ 8'($urandom_range(1, 255));
        end else if (kind < 88) begin
            n = $urandom_range(1, pkt.size() - 1);
            for (i = 0; i < n; i++) void'(pkt.pop_back());
        end else if (kind < 93) begin
            // trailing bytes, partly past a full store
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 96) begin
            pkt.delete();
        end else begin
            pkt.delete();
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
        end
        foreach (pkt[i]) send_item(1'b0, pkt[i], 1'b0, '0);
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // receiver: random ready, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_seen     <= hold_trigger;
        end else if (hold_trigger != hold_seen) begin
            hold_seen     <= hold_trigger;
            hold_left     <= LongHold;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with none expected", m_axis_tdata, 32'h0);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report_mismatch("status", m_axis_tdata[2:0], want.status);
                if (m_axis_tdata[18:3] != want.value)
                    report_mismatch("value", m_axis_tdata[18:3], want.value);
                if (m_axis_tdata[26:19] != want.servo_error)
                    report_mismatch("servo_error", m_axis_tdata[26:19], want.servo_error);
                if (m_axis_tdata[31:27] != 5'd0)
                    report_mismatch("padding", m_axis_tdata[31:27], 32'h0);
                checks_done++;
                status_hits[want.status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("watchdog: no item moved for %0d cycles", StallLimit);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_verdict typed_v;
        int       r;
        int       targets [3];
        int       ph;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        hold_trigger  = 1'b0;
        stall_cycles  = 0;
        mismatches    = 0;
        items_fed     = 0;
        checks_done   = 0;
        cfg_writes    = 0;
        foreach (status_hits[r]) status_hits[r] = 0;
        foreach (pkt_bytes[r]) pkt_bytes[r] = 8'h00;
        pkt_count   = 0;
        held_err    = 8'h00;
        dev_id      = sspc_pkg::DeviceIdReset;
        tx_idle_pct = 19;
        rx_idle_pct = 81;
        targets     = '{520, 1040, 1550};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < 25; r++) begin
            typed_v.status      = DirRows[r].status;
            typed_v.value       = DirRows[r].value;
            typed_v.servo_error = DirRows[r].servo_error;
            send_item(DirRows[r].is_end, DirRows[r].data, DirRows[r].typed, typed_v);
        end
        s_axis_tvalid <= 1'b0;

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_device_id(8'd0);
                    tx_idle_pct = 19;
                    rx_idle_pct = 81;
                end
                1: begin
                    write_device_id(8'd253);
                    tx_idle_pct = 81;
                    rx_idle_pct = 19;
                end
                default: begin
                    write_device_id(8'($urandom_range(2, 252)));
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // stall the output long enough for the input to back up
                    hold_trigger <= ~hold_trigger;
                end
            endcase
            while (items_fed < targets[ph]) send_random_packet();
            s_axis_tvalid <= 1'b0;
        end

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (2 * DrainCycles) @(posedge i_clk);

        $display("run covered %0d input items, %0d packet checks, %0d device id writes",
                 items_fed, checks_done, cfg_writes);
        $display("outcomes: ok %0d, no reply %0d, short %0d, header %0d, id %0d, len %0d, sum %0d",
                 status_hits[sspc_pkg::ST_OK], status_hits[sspc_pkg::ST_NO_RESPONSE],
                 status_hits[sspc_pkg::ST_INCOMPLETE], status_hits[sspc_pkg::ST_BAD_HEADER],
                 status_hits[sspc_pkg::ST_ID_MISMATCH], status_hits[sspc_pkg::ST_BAD_LENGTH],
                 status_hits[sspc_pkg::ST_BAD_CHECKSUM]);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
